[rtl/daf_pkg.sv]
// ----------------------------------------------------------------------------
// daf_pkg
// Shared types, constants and bit helpers for the DRAM address field decoder
// ----------------------------------------------------------------------------
`default_nettype none

package daf_pkg;

  localparam int unsigned AddrW      = 64;
  localparam int unsigned DivStages  = 8;   // quotient bits resolved 8 per stage
  localparam int unsigned DivStepW   = AddrW / DivStages;
  localparam int unsigned CfgIdxW    = 3;

  localparam int unsigned DefSubPartsPerChannel = 2;
  localparam int unsigned DefAddressBits        = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CHIP_MASK      = 3'd0,
    CFG_BANK_MASK      = 3'd1,
    CFG_ROW_MASK       = 3'd2,
    CFG_COLUMN_MASK    = 3'd3,
    CFG_BURST_MASK     = 3'd4,
    CFG_SUBARRAY_MASK  = 3'd5,
    CFG_NUM_CHANNELS   = 3'd6,
    CFG_CHIP_BIT_START = 3'd7
  } daf_cfg_idx_t;

  // one beat moving through the divider stages
  typedef struct packed {
    logic              vld;
    logic [AddrW-1:0]  addr;
    logic [AddrW-1:0]  word;   // dividend, quotient bits overwrite it msb first
    logic [7:0]        rem;
  } daf_div_t;

  // pack the bits of v selected by sel into the low end, lowest first
  function automatic logic [7:0] gather8(logic [7:0] sel, logic [7:0] v);
    logic [7:0] res;
    logic [3:0] k;
    res = '0;
    k   = '0;
    for (int b = 0; b < 8; b++) begin
      if (sel[b]) begin
        res[k[2:0]] = v[b];
        k = k + 4'd1;
      end
    end
    return res;
  endfunction

  function automatic logic [3:0] popcnt8(logic [7:0] v);
    logic [3:0] c;
    c = '0;
    for (int b = 0; b < 8; b++) c = c + {3'b000, v[b]};
    return c;
  endfunction

  // lowest 'need' set bits of m (need at most 3)
  function automatic logic [AddrW-1:0] low_set_bits(logic [AddrW-1:0] m, int unsigned need);
    logic [AddrW-1:0] res;
    logic [AddrW-1:0] rest;
    logic [AddrW-1:0] lsb;
    res  = '0;
    rest = m;
    for (int i = 0; i < 3; i++) begin
      lsb = rest & (~rest + 64'd1);
      if (i < need) begin
        res  = res | lsb;
        rest = rest & ~lsb;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/daf_div_stage.sv]
// ----------------------------------------------------------------------------
// daf_div_stage
// One registered slice of the channel-count divider: eight quotient bits
// ----------------------------------------------------------------------------
`default_nettype none

module daf_div_stage #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic [7:0]        num_channels,
  input  wire daf_pkg::daf_div_t beat_i,
  output daf_pkg::daf_div_t      beat_o
);
  import daf_pkg::*;

  localparam int unsigned Top = AddrW - 1 - STAGE * DivStepW;

  daf_div_t beat_nxt;
  daf_div_t beat_r;

  always_comb begin
    logic [8:0] r;
    beat_nxt = beat_i;
    for (int s = 0; s < DivStepW; s++) begin
      r = {beat_nxt.rem, beat_nxt.word[Top - s]};
      if (r >= {1'b0, num_channels}) begin
        r = r - {1'b0, num_channels};
        beat_nxt.word[Top - s] = 1'b1;
      end else begin
        beat_nxt.word[Top - s] = 1'b0;
      end
      beat_nxt.rem = r[7:0];
    end
  end

  // only the valid bit is reset, the payload just follows the enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else if (en) begin
      beat_r.vld <= beat_nxt.vld;
    end
    if (en) begin
      beat_r.addr <= beat_nxt.addr;
      beat_r.word <= beat_nxt.word;
      beat_r.rem  <= beat_nxt.rem;
    end
  end

  assign beat_o = beat_r;

endmodule

`default_nettype wire

[rtl/daf_gather.sv]
// ----------------------------------------------------------------------------
// daf_gather
// Two-stage parallel bit extract: per-byte packing, then merge by offsets
// ----------------------------------------------------------------------------
`default_nettype none

module daf_gather (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [daf_pkg::AddrW-1:0] sel,
  input  wire logic [daf_pkg::AddrW-1:0] src,
  output logic      [daf_pkg::AddrW-1:0] res
);
  import daf_pkg::*;

  localparam int unsigned Lanes = AddrW / 8;

  logic [7:0]       chunk_nxt [Lanes];
  logic [3:0]       cnt_nxt   [Lanes];
  logic [7:0]       chunk_r   [Lanes];
  logic [3:0]       cnt_r     [Lanes];
  logic [AddrW-1:0] res_nxt;
  logic [AddrW-1:0] res_r;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      chunk_nxt[i] = gather8(sel[8*i +: 8], src[8*i +: 8]);
      cnt_nxt[i]   = popcnt8(sel[8*i +: 8]);
    end
  end

  always_comb begin
    logic [6:0] off;
    off     = '0;
    res_nxt = '0;
    for (int i = 0; i < Lanes; i++) begin
      res_nxt = res_nxt | ({{(AddrW-8){1'b0}}, chunk_r[i]} << off);
      off     = off + {3'b000, cnt_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < Lanes; i++) begin
        chunk_r[i] <= chunk_nxt[i];
        cnt_r[i]   <= cnt_nxt[i];
      end
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

`default_nettype wire

[rtl/dram_address_field_decoder_core.sv]
// ----------------------------------------------------------------------------
// dram_address_field_decoder_core
// Pipelined decode of a physical address into DRAM coordinates
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  in      | in_valid, in_stall, in_physical_address | address beats in
//  out     | out_valid, out_stall, out_<field>       | decoded beats out
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata         | register writes
//
//  one beat accepted per cycle while not stalled; stages are the input register,
//  eight divider stages of eight quotient bits each, splice, two gather stages
//  and the output register
//  synchronous reset clears valid bits and loads register defaults
//  a stall at the output while out_valid is high freezes every stage together; in_stall follows it
// ----------------------------------------------------------------------------
`default_nettype none

module dram_address_field_decoder_core #(
  parameter int unsigned SUB_PARTITIONS_PER_CHANNEL = daf_pkg::DefSubPartsPerChannel,
  parameter int unsigned ADDRESS_BITS               = daf_pkg::DefAddressBits
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [63:0]                  in_physical_address,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [7:0]                   out_chip,
  output logic      [7:0]                   out_bank,
  output logic      [31:0]                  out_row,
  output logic      [15:0]                  out_column,
  output logic      [7:0]                   out_burst,
  output logic      [10:0]                  out_subpart,
  output logic      [63:0]                  out_subarray,
  output logic      [63:0]                  out_part_addr,
  input  wire logic                         cfg_wr_en,
  input  wire logic [daf_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [63:0]                  cfg_wdata
);
  import daf_pkg::*;

  localparam logic [AddrW-1:0] AMask = (ADDRESS_BITS >= AddrW) ? '1 :
                                       ((64'd1 << ADDRESS_BITS) - 64'd1);
  localparam int unsigned SpidNeed = $clog2(SUB_PARTITIONS_PER_CHANNEL + 1) - 1;
  localparam logic [7:0]  SpLowMask = 8'(SUB_PARTITIONS_PER_CHANNEL - 1);
  localparam logic [10:0] SpMul     = 11'(SUB_PARTITIONS_PER_CHANNEL);

  // configuration registers
  logic [63:0] chip_mask_r, bank_mask_r, row_mask_r, column_mask_r;
  logic [63:0] burst_mask_r, subarray_mask_r;
  logic [7:0]  num_channels_r;
  logic [4:0]  chip_bit_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_mask_r      <= 64'h0000_0000_0000_1C00;
      bank_mask_r      <= 64'h0000_0000_0000_0300;
      row_mask_r       <= 64'h0000_0000_0FFF_0000;
      column_mask_r    <= 64'h0000_0000_0000_E0FF;
      burst_mask_r     <= 64'h0000_0000_0000_000F;
      subarray_mask_r  <= '0;
      num_channels_r   <= 8'd8;
      chip_bit_start_r <= 5'd10;
    end else if (cfg_wr_en) begin
      unique case (daf_cfg_idx_t'(cfg_index))
        CFG_CHIP_MASK:      chip_mask_r      <= cfg_wdata;
        CFG_BANK_MASK:      bank_mask_r      <= cfg_wdata;
        CFG_ROW_MASK:       row_mask_r       <= cfg_wdata;
        CFG_COLUMN_MASK:    column_mask_r    <= cfg_wdata;
        CFG_BURST_MASK:     burst_mask_r     <= cfg_wdata;
        CFG_SUBARRAY_MASK:  subarray_mask_r  <= cfg_wdata;
        CFG_NUM_CHANNELS:   num_channels_r   <= cfg_wdata[7:0];
        CFG_CHIP_BIT_START: chip_bit_start_r <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  // static decode of the configuration
  logic        pow2;
  logic [63:0] spid;
  logic [63:0] part_mask;
  logic [63:0] low_mask;

  assign pow2      = (num_channels_r & (num_channels_r - 8'd1)) == 8'd0;
  assign spid      = low_set_bits(bank_mask_r, SpidNeed);
  assign part_mask = pow2 ? ~(chip_mask_r | spid) : ~spid;
  assign low_mask  = (64'd1 << chip_bit_start_r) - 64'd1;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // input register
  logic        v0_r;
  logic [63:0] addr0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) addr0_r <= in_physical_address & AMask;
  end

  // divider: address above the chip start bit over the channel count
  daf_div_t div_s [DivStages+1];

  assign div_s[0].vld  = v0_r;
  assign div_s[0].addr = addr0_r;
  assign div_s[0].word = addr0_r >> chip_bit_start_r;
  assign div_s[0].rem  = '0;

  for (genvar g = 0; g < DivStages; g++) begin : g_div
    daf_div_stage #(.STAGE(g)) u_div (
      .clk          (clk),
      .rst_n        (rst_n),
      .en           (en),
      .num_channels (num_channels_r),
      .beat_i       (div_s[g]),
      .beat_o       (div_s[g+1])
    );
  end

  // splice quotient back over the low bits, or pass the address as is when pow2 is set
  logic        v1_r;
  logic [63:0] src1_r;
  logic [63:0] sub1_r;
  logic [7:0]  rem1_r;
  logic [63:0] src_nxt;

  assign src_nxt = pow2 ? div_s[DivStages].addr :
                   ((div_s[DivStages].word << chip_bit_start_r) |
                    (div_s[DivStages].addr & low_mask));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= div_s[DivStages].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      src1_r <= src_nxt;
      sub1_r <= div_s[DivStages].addr & subarray_mask_r;
      rem1_r <= div_s[DivStages].rem;
    end
  end

  // field extracts
  logic [63:0] g_chip, g_bank, g_row, g_col, g_burst, g_part;

  daf_gather u_g_chip  (.clk(clk), .en(en), .sel(chip_mask_r),   .src(src1_r), .res(g_chip));
  daf_gather u_g_bank  (.clk(clk), .en(en), .sel(bank_mask_r),   .src(src1_r), .res(g_bank));
  daf_gather u_g_row   (.clk(clk), .en(en), .sel(row_mask_r),    .src(src1_r), .res(g_row));
  daf_gather u_g_col   (.clk(clk), .en(en), .sel(column_mask_r), .src(src1_r), .res(g_col));
  daf_gather u_g_burst (.clk(clk), .en(en), .sel(burst_mask_r),  .src(src1_r), .res(g_burst));
  daf_gather u_g_part  (.clk(clk), .en(en), .sel(part_mask),     .src(src1_r), .res(g_part));

  // sideband alongside the two gather stages
  logic        v2_r, v3_r;
  logic [63:0] sub2_r, sub3_r;
  logic [7:0]  rem2_r, rem3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sub2_r <= sub1_r;
      sub3_r <= sub2_r;
      rem2_r <= rem1_r;
      rem3_r <= rem2_r;
    end
  end

  // output register
  logic [7:0]  chip_nxt;
  logic [10:0] sp_nxt;
  logic        out_valid_r;
  logic [7:0]  chip_r, bank_r, burst_r;
  logic [31:0] row_r;
  logic [15:0] col_r;
  logic [10:0] sp_r;
  logic [63:0] sub_r, part_r;

  assign chip_nxt = pow2 ? g_chip[7:0] : rem3_r;
  assign sp_nxt   = 11'({3'b000, chip_nxt} * SpMul) + {3'b000, g_bank[7:0] & SpLowMask};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chip_r  <= chip_nxt;
      bank_r  <= g_bank[7:0];
      row_r   <= g_row[31:0];
      col_r   <= g_col[15:0];
      burst_r <= g_burst[7:0];
      sp_r    <= sp_nxt;
      sub_r   <= sub3_r;
      part_r  <= g_part;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_chip      = chip_r;
  assign out_bank      = bank_r;
  assign out_row       = row_r;
  assign out_column    = col_r;
  assign out_burst     = burst_r;
  assign out_subpart   = sp_r;
  assign out_subarray  = sub_r;
  assign out_part_addr = part_r;

endmodule

`default_nettype wire

[test/dram_address_field_decoder_core_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dram_address_field_decoder_core_checker
// Watches the in, out and cfg channels, predicts each decoded beat and compares field by field
// ----------------------------------------------------------------------------
`default_nettype none

module dram_address_field_decoder_core_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [63:0] in_physical_address,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [7:0]  out_chip,
  input  wire logic [7:0]  out_bank,
  input  wire logic [31:0] out_row,
  input  wire logic [15:0] out_column,
  input  wire logic [7:0]  out_burst,
  input  wire logic [10:0] out_subpart,
  input  wire logic [63:0] out_subarray,
  input  wire logic [63:0] out_part_addr,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  output int               fail_count,
  output int               pending_count
);
  import daf_pkg::*;

  localparam int unsigned SubParts = 2;

  typedef struct packed {
    logic [7:0]  chip;
    logic [7:0]  bank;
    logic [31:0] row;
    logic [15:0] column;
    logic [7:0]  burst;
    logic [10:0] subpart;
    logic [63:0] subarray;
    logic [63:0] part_addr;
  } decoded_t;

  logic [63:0] m_chip, m_bank, m_row, m_col, m_burst, m_sub;
  logic [7:0]  n_chan;
  logic [4:0]  bit_start;
  decoded_t    decoded_q[$];

  function automatic logic [63:0] pext(logic [63:0] sel, logic [63:0] v);
    logic [63:0] r;
    int k;
    r = '0;
    k = 0;
    for (int b = 0; b < 64; b++) begin
      if (sel[b]) begin
        r[k] = v[b];
        k++;
      end
    end
    return r;
  endfunction

  function automatic decoded_t decode_address(logic [63:0] addr);
    decoded_t d;
    logic [63:0] spid, src, hi, low, chip;
    int need, have;
    need = 0;
    while ((2 << need) <= SubParts) need++;
    spid = '0;
    have = 0;
    for (int b = 0; b < 64; b++) begin
      if (have < need && m_bank[b]) begin
        spid[b] = 1'b1;
        have++;
      end
    end
    if ((n_chan & (n_chan - 8'd1)) == 8'd0) begin
      chip = pext(m_chip, addr);
      src = addr;
      d.part_addr = pext(~(m_chip | spid), addr);
    end else begin
      low = (64'd1 << bit_start) - 64'd1;
      hi = addr >> bit_start;
      chip = hi % {56'd0, n_chan};
      src = ((hi / {56'd0, n_chan}) << bit_start) | (addr & low);
      d.part_addr = pext(~spid, src);
    end
    d.chip = chip[7:0];
    d.bank = 8'(pext(m_bank, src));
    d.row = 32'(pext(m_row, src));
    d.column = 16'(pext(m_col, src));
    d.burst = 8'(pext(m_burst, src));
    d.subpart = 11'({3'd0, d.chip} * SubParts + (d.bank & (SubParts - 1)));
    d.subarray = addr & m_sub;
    return d;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch %s at %0t", msg, $realtime);
    fail_count++;
  endtask

  task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %h expected %h", what, got, want));
  endtask

  assign pending_count = decoded_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    decoded_t w;
    if (!rst_n) begin
      m_chip <= 64'h1C00; m_bank <= 64'h300; m_row <= 64'h0FFF0000;
      m_col <= 64'hE0FF; m_burst <= 64'hF; m_sub <= '0;
      n_chan <= 8'd8; bit_start <= 5'd10;
    end else begin
      if (cfg_wr_en) begin
        case (daf_cfg_idx_t'(cfg_index))
          CFG_CHIP_MASK:      m_chip <= cfg_wdata;
          CFG_BANK_MASK:      m_bank <= cfg_wdata;
          CFG_ROW_MASK:       m_row <= cfg_wdata;
          CFG_COLUMN_MASK:    m_col <= cfg_wdata;
          CFG_BURST_MASK:     m_burst <= cfg_wdata;
          CFG_SUBARRAY_MASK:  m_sub <= cfg_wdata;
          CFG_NUM_CHANNELS:   n_chan <= cfg_wdata[7:0];
          CFG_CHIP_BIT_START: bit_start <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decoded_q.push_back(decode_address(in_physical_address));
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected beat");
        end else begin
          w = decoded_q.pop_front();
          compare_field("chip", 64'(out_chip), 64'(w.chip));
          compare_field("bank", 64'(out_bank), 64'(w.bank));
          compare_field("row", 64'(out_row), 64'(w.row));
          compare_field("column", 64'(out_column), 64'(w.column));
          compare_field("burst", 64'(out_burst), 64'(w.burst));
          compare_field("subpart", 64'(out_subpart), 64'(w.subpart));
          compare_field("subarray", out_subarray, w.subarray);
          compare_field("part_addr", out_part_addr, w.part_addr);
        end
      end
    end
  end

endmodule

`default_nettype wire

[test/dram_address_field_decoder_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dram_address_field_decoder_core_test
// Drives address beats and register settings with random gaps and stalls;
// the checker predicts every decoded beat
// ----------------------------------------------------------------------------
`default_nettype none

module dram_address_field_decoder_core_test;
  import daf_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_physical_address;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_chip, out_bank, out_burst;
  logic [31:0] out_row;
  logic [15:0] out_column;
  logic [10:0] out_subpart;
  logic [63:0] out_subarray, out_part_addr;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  int          fail_count;
  int          pending_count;
  bit          stall_enable;

  dram_address_field_decoder_core u_top (.*);

  dram_address_field_decoder_core_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stall stretches per beat
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_enable && out_valid && !out_stall) begin
        n = $urandom_range(0, 16);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_mask();
    case ($urandom_range(0, 4))
      0: return rand64();
      1: return 64'(({$urandom(), $urandom()} & 64'hFF) << $urandom_range(0, 56));
      2: return '0;
      3: return '1;
      default: return rand64() & rand64();
    endcase
  endfunction

  function automatic logic [63:0] rand_address();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return rand64() >> $urandom_range(0, 63);
      default: return rand64();
    endcase
  endfunction

  task automatic write_reg(daf_cfg_idx_t idx, logic [63:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_address(logic [63:0] addr, bit with_gap);
    int gap;
    gap = with_gap ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_physical_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    logic [7:0] chans[6];
    chans = '{8'd8, 8'd3, 8'd0, 8'd255, 8'd1, 8'd6};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_physical_address = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    stall_enable = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults, then the modulo and wide-start special cases, no gaps
    for (int i = 0; i < 8; i++) send_address(i[0] ? '1 : 64'(i) << (i * 8), 1'b0);
    drain();
    write_reg(CFG_SUBARRAY_MASK, '1);
    write_reg(CFG_NUM_CHANNELS, 64'hFFFF_FF03);
    write_reg(CFG_CHIP_BIT_START, 64'hFFFF_FFFF);
    send_address('1, 1'b0);
    send_address(64'h8000_0000_0000_0000, 1'b0);
    send_address('0, 1'b0);
    drain();
    write_reg(CFG_CHIP_BIT_START, 64'd0);
    write_reg(CFG_NUM_CHANNELS, 64'd0);
    send_address('1, 1'b0);
    send_address(64'h1234_5678_9ABC_DEF0, 1'b0);
    drain();
    write_reg(CFG_NUM_CHANNELS, 64'd255);
    write_reg(CFG_BANK_MASK, '0);
    send_address('1, 1'b0);
    send_address(64'hFEDC_BA98_7654_3210, 1'b0);
    drain();

    stall_enable = 1'b1;
    for (int phase = 0; phase < 12; phase++) begin
      write_reg(CFG_CHIP_MASK, rand_mask());
      write_reg(CFG_BANK_MASK, rand_mask());
      write_reg(CFG_ROW_MASK, rand_mask());
      write_reg(CFG_COLUMN_MASK, rand_mask());
      write_reg(CFG_BURST_MASK, rand_mask());
      write_reg(CFG_SUBARRAY_MASK, rand_mask());
      write_reg(CFG_NUM_CHANNELS, (rand64() & ~64'hFF) | {56'd0, chans[phase % 6]});
      write_reg(CFG_CHIP_BIT_START, phase < 2 ? 64'(phase * 31) : rand64());
      // odd phases run back to back
      for (int i = 0; i < 50; i++) send_address(rand_address(), phase[0] == 1'b0);
      drain();
    end

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/daf_pkg.sv
rtl/daf_div_stage.sv
rtl/daf_gather.sv
rtl/dram_address_field_decoder_core.sv
test/dram_address_field_decoder_core_checker.sv
test/dram_address_field_decoder_core_test.sv
